// ----- rtl/csma_ca_mac_controller_top_assert.svh -----
// ----------------------------------------------------------------------------
// CSMA/CA MAC controller assertion macros
// Shared property forms for the port-level checker of the MAC controller.
// ----------------------------------------------------------------------------
`ifndef CSMA_CA_MAC_CONTROLLER_TOP_ASSERT_SVH
`define CSMA_CA_MAC_CONTROLLER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSMA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/csma_pkg.sv -----
// ----------------------------------------------------------------------------
// CSMA/CA MAC controller package
// Event and result layouts, configuration layout and the codes they carry.
// ----------------------------------------------------------------------------
`default_nettype none

package csma_pkg;

   // Event kinds
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_SEND  = 2'd1;
   localparam logic [1:0] OP_FRAME = 2'd2;

   // Received frame kinds
   localparam logic [1:0] FT_DATA = 2'd0;
   localparam logic [1:0] FT_ACK  = 2'd1;
   localparam logic [1:0] FT_NACK = 2'd2;

   // Transmit commands
   localparam logic [2:0] TX_NONE   = 3'd0;
   localparam logic [2:0] TX_SEND   = 3'd1;
   localparam logic [2:0] TX_RESEND = 3'd2;
   localparam logic [2:0] TX_ACK    = 3'd3;
   localparam logic [2:0] TX_NACK   = 3'd4;

   // MAC modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_DEFER   = 3'd1;
   localparam logic [2:0] MODE_FIRST   = 3'd2;
   localparam logic [2:0] MODE_WAITACK = 3'd3;
   localparam logic [2:0] MODE_RETRY   = 3'd4;

   // Broadcast address
   localparam logic [7:0] BCAST_ADDR = 8'hFF;

   // Register indexes
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_ADDR_BITS-1:0] REG_OWN_ADDR     = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_OWN_GROUP    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_DIFS_TICKS   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ACK_TIMEOUT  = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_WINDOW_LOG2  = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_MAX_ATTEMPTS = 3'd5;

   typedef struct packed {
      logic [7:0]  own_addr;
      logic [7:0]  own_group;
      logic [15:0] difs_ticks;
      logic [15:0] ack_timeout_ticks;
      logic [3:0]  window_log2;
      logic [3:0]  max_attempts;
   } csma_cfg_type;

   // Packed so that the lowest field sits in the lowest bits; opcode on top.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] random_draw;
      logic [7:0]  frame_group;
      logic [7:0]  frame_src;
      logic [7:0]  frame_dest;
      logic        frame_crc_ok;
      logic [1:0]  frame_type;
      logic [7:0]  dest_addr;
      logic        channel_busy;
   } csma_item_type;

   typedef struct packed {
      logic [3:0] retry_now;
      logic [2:0] mac_status;
      logic       give_up;
      logic       ack_seen;
      logic       deliver_to_app;
      logic       request_accepted;
      logic [7:0] tx_dest;
      logic [2:0] tx_command;
   } csma_result_type;

   localparam int REQ_TUSER_BITS = 2;
   localparam int ITEM_DATA_BITS = $bits(csma_item_type) - REQ_TUSER_BITS;
   localparam int REQ_TDATA_BITS = ((ITEM_DATA_BITS + 7) / 8) * 8;
   localparam int RESULT_BITS    = $bits(csma_result_type);
   localparam int RSP_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- rtl/csma_ca_mac_controller_top.sv -----
// ----------------------------------------------------------------------------
// CSMA/CA MAC controller top level
// Medium access controller for a shared RS485 bus with backoff and ACK retry.
// ----------------------------------------------------------------------------
// The controller takes one event beat per clock cycle (tick, send request or
// received frame) and returns exactly one result beat for each. An event
// registered at the input stage is evaluated in a single pass by the engine,
// which updates the MAC state and loads the result register on the same edge;
// the result appears on rsp_tvalid from the result register, which the engine
// loads from the input stage whenever the result register is free.
// The input stage frees itself whenever its beat moves to the result register,
// so one beat per cycle is sustained as long as the result side is drained;
// when rsp_tready is held low the stages fill and req_tready drops.
// Configuration registers are written through csr_we/csr_addr/csr_wdata and
// should be changed only while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module csma_ca_mac_controller_top #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Event channel
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // channel_busy, dest_addr, frame_type, frame_crc_ok, frame_dest,
   // frame_src, frame_group, random_draw (lowest bit up), zero filled
   input  wire logic [csma_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // opcode
   input  wire logic [csma_pkg::REQ_TUSER_BITS-1:0] req_tuser,
   // Result channel
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tx_command, tx_dest, request_accepted, deliver_to_app, ack_seen,
   // give_up, mac_status, retry_now (lowest bit up), zero filled
   output      logic [csma_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // Configuration write port
   input  wire logic                                 csr_we,
   input  wire logic [csma_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [csma_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   csma_pkg::csma_cfg_type    cfg;
   csma_pkg::csma_item_type   item_ff;
   csma_pkg::csma_result_type result;
   csma_pkg::csma_result_type rsp_data_ff;

   logic in_valid_ff, in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic fire;
   logic req_take;

   // The engine may process the held beat when the result register is empty
   // or being drained in this cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= {req_tuser, req_tdata[csma_pkg::ITEM_DATA_BITS-1:0]};
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   csma_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   csma_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = csma_pkg::RSP_TDATA_BITS'(rsp_data_ff);

endmodule

`default_nettype wire

// ----- rtl/csma_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// CSMA/CA configuration registers
// Holds the station settings written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module csma_cfg_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [csma_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [csma_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output csma_pkg::csma_cfg_type                   cfg
);

   csma_pkg::csma_cfg_type cfg_ff;
   csma_pkg::csma_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            csma_pkg::REG_OWN_ADDR:     cfg_in.own_addr          = csr_wdata[7:0];
            csma_pkg::REG_OWN_GROUP:    cfg_in.own_group         = csr_wdata[7:0];
            csma_pkg::REG_DIFS_TICKS:   cfg_in.difs_ticks        = csr_wdata[15:0];
            csma_pkg::REG_ACK_TIMEOUT:  cfg_in.ack_timeout_ticks = csr_wdata[15:0];
            csma_pkg::REG_WINDOW_LOG2:  cfg_in.window_log2       = csr_wdata[3:0];
            csma_pkg::REG_MAX_ATTEMPTS: cfg_in.max_attempts      = csr_wdata[3:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_addr          <= 8'd1;
         cfg_ff.own_group         <= 8'd0;
         cfg_ff.difs_ticks        <= 16'd10;
         cfg_ff.ack_timeout_ticks <= 16'd100;
         cfg_ff.window_log2       <= 4'd4;
         cfg_ff.max_attempts      <= 4'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/csma_engine.sv -----
// ----------------------------------------------------------------------------
// CSMA/CA MAC engine
// MAC state registers and the single-pass event logic that updates them.
// ----------------------------------------------------------------------------
`default_nettype none

module csma_engine #(
   parameter int TIMER_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  csma_pkg::csma_item_type    item,
   input  csma_pkg::csma_cfg_type     cfg,
   output csma_pkg::csma_result_type  result
);

   localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [TIMER_BITS-1:0] TMASK = {TIMER_BITS{1'b1}};

   logic [2:0]            mode_ff,   mode_in;
   logic                  clear_ff,  clear_in;
   logic                  run_ff,    run_in;
   logic [TIMER_BITS-1:0] difs_ff,   difs_in;
   logic [TIMER_BITS-1:0] boff_ff,   boff_in;
   logic [TIMER_BITS-1:0] ackw_ff,   ackw_in;
   logic [3:0]            retry_ff,  retry_in;
   logic [7:0]            pdest_ff,  pdest_in;

   logic [CW-1:0]         difs_lim;
   logic [CW-1:0]         ack_lim;
   logic [TIMER_BITS-1:0] difs_step;
   logic                  mine;
   csma_pkg::csma_result_type res;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
      return (v == TMASK) ? v : v + TIMER_BITS'(1);
   endfunction

   function automatic logic [CW-1:0] lim(input logic [15:0] v);
      logic [CW-1:0] ve;
      logic [CW-1:0] me;
      ve = CW'(v);
      me = CW'(TMASK);
      return (ve > me) ? me : ve;
   endfunction

   // Backoff draw: random value masked to the contention window 2^e - 1.
   function automatic logic [TIMER_BITS-1:0] draw(input logic [15:0] rnd,
                                                   input logic [4:0]  e);
      logic [TIMER_BITS-1:0] m;
      logic [CW-1:0]         r;
      m = ({1'b0, e} >= 6'(TIMER_BITS)) ? TMASK : ~(TMASK << e);
      r = CW'(rnd);
      return r[TIMER_BITS-1:0] & m;
   endfunction

   assign difs_lim = lim(cfg.difs_ticks);
   assign ack_lim  = lim(cfg.ack_timeout_ticks);
   assign mine     = (item.frame_dest == cfg.own_addr) ||
                     (item.frame_dest == csma_pkg::BCAST_ADDR &&
                      item.frame_group == cfg.own_group);

   always_comb begin
      mode_in   = mode_ff;
      clear_in  = clear_ff;
      run_in    = run_ff;
      difs_in   = difs_ff;
      boff_in   = boff_ff;
      ackw_in   = ackw_ff;
      retry_in  = retry_ff;
      pdest_in  = pdest_ff;
      difs_step = difs_ff;
      res       = '0;
      case (item.opcode)
         csma_pkg::OP_TICK: begin
            if (mode_ff == csma_pkg::MODE_WAITACK) begin
               ackw_in = sat_inc(ackw_ff);
            end
            if (item.channel_busy) begin
               clear_in = 1'b0;
               run_in   = 1'b0;
               difs_in  = '0;
            end else begin
               // Backoff counts down only on idle ticks and fires at zero.
               if (mode_ff == csma_pkg::MODE_FIRST || mode_ff == csma_pkg::MODE_RETRY) begin
                  if (boff_ff == '0) begin
                     res.tx_command = (mode_ff == csma_pkg::MODE_FIRST) ?
                                      csma_pkg::TX_SEND : csma_pkg::TX_RESEND;
                     res.tx_dest    = pdest_ff;
                     if (pdest_ff == csma_pkg::BCAST_ADDR) begin
                        mode_in = csma_pkg::MODE_IDLE;
                     end else begin
                        mode_in = csma_pkg::MODE_WAITACK;
                        ackw_in = '0;
                     end
                  end else begin
                     boff_in = boff_ff - TIMER_BITS'(1);
                  end
               end
               if (!clear_ff) begin
                  difs_step = sat_inc(run_ff ? difs_ff : '0);
                  difs_in   = difs_step;
                  run_in    = 1'b1;
                  if (CW'(difs_step) >= difs_lim) begin
                     clear_in = 1'b1;
                     run_in   = 1'b0;
                  end
               end
               if (clear_in) begin
                  if (mode_in == csma_pkg::MODE_DEFER) begin
                     retry_in = '0;
                     boff_in  = draw(item.random_draw, {1'b0, cfg.window_log2});
                     mode_in  = csma_pkg::MODE_FIRST;
                  end else if (mode_in == csma_pkg::MODE_WAITACK &&
                               CW'(ackw_in) >= ack_lim) begin
                     if (retry_ff < cfg.max_attempts) begin
                        boff_in  = draw(item.random_draw,
                                        {1'b0, cfg.window_log2} + {1'b0, retry_ff});
                        retry_in = retry_ff + 4'd1;
                        mode_in  = csma_pkg::MODE_RETRY;
                     end else begin
                        res.give_up = 1'b1;
                        retry_in    = '0;
                        mode_in     = csma_pkg::MODE_IDLE;
                     end
                  end
               end
            end
         end
         csma_pkg::OP_SEND: begin
            if (mode_ff == csma_pkg::MODE_IDLE) begin
               res.request_accepted = 1'b1;
               pdest_in             = item.dest_addr;
               retry_in             = '0;
               if (clear_ff) begin
                  res.tx_command = csma_pkg::TX_SEND;
                  res.tx_dest    = item.dest_addr;
                  if (item.dest_addr == csma_pkg::BCAST_ADDR) begin
                     mode_in = csma_pkg::MODE_IDLE;
                  end else begin
                     mode_in = csma_pkg::MODE_WAITACK;
                     ackw_in = '0;
                  end
               end else begin
                  mode_in = csma_pkg::MODE_DEFER;
               end
            end
         end
         csma_pkg::OP_FRAME: begin
            if (mine) begin
               if (!item.frame_crc_ok) begin
                  if (mode_ff == csma_pkg::MODE_WAITACK) begin
                     if (retry_ff < cfg.max_attempts) begin
                        boff_in  = draw(item.random_draw,
                                        {1'b0, cfg.window_log2} + {1'b0, retry_ff});
                        retry_in = retry_ff + 4'd1;
                        mode_in  = csma_pkg::MODE_RETRY;
                     end else begin
                        res.give_up = 1'b1;
                        retry_in    = '0;
                        mode_in     = csma_pkg::MODE_IDLE;
                     end
                  end
                  if (item.frame_type == csma_pkg::FT_DATA &&
                      item.frame_dest == csma_pkg::BCAST_ADDR) begin
                     res.tx_command = csma_pkg::TX_NACK;
                     res.tx_dest    = item.frame_src;
                  end
               end else if (item.frame_type == csma_pkg::FT_DATA) begin
                  res.deliver_to_app = 1'b1;
                  if (item.frame_dest != csma_pkg::BCAST_ADDR) begin
                     res.tx_command = csma_pkg::TX_ACK;
                     res.tx_dest    = item.frame_src;
                  end
               end else if (item.frame_type == csma_pkg::FT_ACK) begin
                  if (mode_ff == csma_pkg::MODE_WAITACK || mode_ff == csma_pkg::MODE_RETRY) begin
                     res.ack_seen = 1'b1;
                     retry_in     = '0;
                     mode_in      = csma_pkg::MODE_IDLE;
                  end
               end else if (item.frame_type == csma_pkg::FT_NACK) begin
                  if (mode_ff == csma_pkg::MODE_IDLE) begin
                     if (clear_ff) begin
                        res.tx_command = csma_pkg::TX_RESEND;
                        res.tx_dest    = pdest_ff;
                        if (pdest_ff == csma_pkg::BCAST_ADDR) begin
                           mode_in = csma_pkg::MODE_IDLE;
                        end else begin
                           mode_in = csma_pkg::MODE_WAITACK;
                           ackw_in = '0;
                        end
                     end else begin
                        mode_in  = csma_pkg::MODE_DEFER;
                        retry_in = '0;
                     end
                  end
               end
            end
         end
         default: begin
            res = '0;
         end
      endcase
      res.mac_status = mode_in;
      res.retry_now  = retry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= csma_pkg::MODE_IDLE;
         clear_ff <= 1'b1;
         run_ff   <= 1'b0;
         difs_ff  <= '0;
         boff_ff  <= '0;
         ackw_ff  <= '0;
         retry_ff <= '0;
         pdest_ff <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         clear_ff <= clear_in;
         run_ff   <= run_in;
         difs_ff  <= difs_in;
         boff_ff  <= boff_in;
         ackw_ff  <= ackw_in;
         retry_ff <= retry_in;
         pdest_ff <= pdest_in;
      end
   end

   assign result = res;

endmodule

`default_nettype wire

// ----- rtl/csma_checker.sv -----
// ----------------------------------------------------------------------------
// CSMA/CA MAC controller port checker
// Watches the result channel of the top level for inconsistent result beats.
// ----------------------------------------------------------------------------
`default_nettype none

`include "csma_ca_mac_controller_top_assert.svh"

module csma_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [csma_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);

   csma_pkg::csma_result_type rsp;

   assign rsp = rsp_tdata[csma_pkg::RESULT_BITS-1:0];

   // A stalled result beat stays and keeps its payload.
   `CSMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result beat changed while stalled")

   // No transmit command means no destination.
   `CSMA_ASSERT_SAME(a_idle_dest, clock, reset, rsp_tvalid && rsp.tx_command == csma_pkg::TX_NONE, rsp.tx_dest == 8'd0, "destination set without a command")

   // An accepted request either sends at once or defers.
   `CSMA_ASSERT_SAME(a_req_mode, clock, reset, rsp_tvalid && rsp.request_accepted, (rsp.tx_command == csma_pkg::TX_SEND && (rsp.mac_status == csma_pkg::MODE_IDLE || rsp.mac_status == csma_pkg::MODE_WAITACK)) || (rsp.tx_command == csma_pkg::TX_NONE && rsp.mac_status == csma_pkg::MODE_DEFER), "accepted request left an odd mode")

   // Giving up or taking an ACK ends the transfer with a cleared retry count.
   `CSMA_ASSERT_SAME(a_done_idle, clock, reset, rsp_tvalid && (rsp.give_up || rsp.ack_seen), rsp.mac_status == csma_pkg::MODE_IDLE && rsp.retry_now == 4'd0, "transfer end did not return to idle")

endmodule

bind csma_ca_mac_controller_top csma_checker u_csma_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSMA/CA MAC controller testbench
// Drives event beats into the MAC controller, predicts every result beat with
// an in-bench model of the MAC state, and checks the results field by field.
// ----------------------------------------------------------------------------

module tb_top;
   import csma_pkg::*;

   // Timer width used by both the block and the in-bench predictor.
   localparam int TIMER_W = 16;
   // An opcode outside the defined set; the block must treat it as no event.
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [1:0] FT_UNKNOWN = 2'd3;
   // Receiver hold-off used once to back the block up into its input.
   localparam int LONG_HOLD = 150;
   // Cycles without any beat on either side before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 4000;

   logic clock;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [REQ_TUSER_BITS-1:0] req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_addr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   csma_ca_mac_controller_top #(
      .TIMER_BITS(TIMER_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock period, starting low.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ------------------------------------------------------------------------
   // Predictor: a private copy of the MAC configuration and state, advanced
   // once for every event beat that the block accepts.
   // ------------------------------------------------------------------------
   csma_cfg_type mac_cfg;
   logic [2:0]   st_mode;
   logic         st_clear;
   logic         st_idle_run;
   logic [15:0]  st_difs_cnt;
   logic [15:0]  st_backoff;
   logic [15:0]  st_ack_wait;
   logic [3:0]   st_retry;
   logic [7:0]   st_pending;

   csma_item_type   pending_events[$];
   csma_result_type expected_results[$];

   // Handshake outcomes of the latest rising edge, read by the falling-edge
   // processes that drive the next beat.
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic no_gaps = 1'b0;
   logic long_hold_req = 1'b0;
   int   req_gap = 0;
   int   rsp_wait = 0;
   int   idle_cycles = 0;
   int   errors = 0;
   int   beats_in = 0;
   int   beats_out = 0;
   int   phases = 0;
   int   tx_count = 0;
   int   give_up_count = 0;
   int   deliver_count = 0;

   task automatic mac_reset();
      mac_cfg.own_addr          = 8'd1;
      mac_cfg.own_group         = 8'd0;
      mac_cfg.difs_ticks        = 16'd10;
      mac_cfg.ack_timeout_ticks = 16'd100;
      mac_cfg.window_log2       = 4'd4;
      mac_cfg.max_attempts      = 4'd3;
      st_mode     = MODE_IDLE;
      st_clear    = 1'b1;
      st_idle_run = 1'b0;
      st_difs_cnt = '0;
      st_backoff  = '0;
      st_ack_wait = '0;
      st_retry    = '0;
      st_pending  = '0;
   endtask

   // Timers stick at their top value instead of wrapping.
   function automatic logic [15:0] timer_inc(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   // The contention window doubles with every retry; once the exponent
   // covers the whole timer the draw is taken as is.
   function automatic logic [15:0] backoff_draw(logic [15:0] rnd);
      int unsigned e;
      e = int'(mac_cfg.window_log2) + int'(st_retry);
      if (e >= TIMER_W)
         return rnd;
      return rnd & 16'((32'd1 << e) - 32'd1);
   endfunction

   function automatic void retry_or_drop(logic [15:0] rnd, inout csma_result_type r);
      if (st_retry < mac_cfg.max_attempts) begin
         st_backoff = backoff_draw(rnd);
         st_retry   = st_retry + 4'd1;
         st_mode    = MODE_RETRY;
      end else begin
         r.give_up = 1'b1;
         st_retry  = '0;
         st_mode   = MODE_IDLE;
      end
   endfunction

   // Put the pending frame on the bus; multicast needs no ACK.
   function automatic void launch(logic [2:0] cmd, inout csma_result_type r);
      r.tx_command = cmd;
      r.tx_dest    = st_pending;
      if (st_pending == BCAST_ADDR) begin
         st_mode = MODE_IDLE;
      end else begin
         st_mode     = MODE_WAITACK;
         st_ack_wait = '0;
      end
   endfunction

   function automatic void start_send(logic [2:0] cmd, inout csma_result_type r);
      if (st_clear) begin
         launch(cmd, r);
      end else begin
         st_mode  = MODE_DEFER;
         st_retry = '0;
      end
   endfunction

   function automatic csma_result_type mac_step(csma_item_type ev);
      csma_result_type r;
      logic mine;
      r = '0;
      case (ev.opcode)
         OP_TICK: begin
            if (st_mode == MODE_WAITACK)
               st_ack_wait = timer_inc(st_ack_wait);
            if (ev.channel_busy) begin
               st_clear    = 1'b0;
               st_idle_run = 1'b0;
               st_difs_cnt = '0;
            end else begin
               // Backoff only runs down on idle ticks and is frozen otherwise.
               if (st_mode == MODE_FIRST || st_mode == MODE_RETRY) begin
                  if (st_backoff == 16'd0)
                     launch((st_mode == MODE_FIRST) ? TX_SEND : TX_RESEND, r);
                  else
                     st_backoff = st_backoff - 16'd1;
               end
               if (!st_clear) begin
                  if (!st_idle_run) begin
                     st_idle_run = 1'b1;
                     st_difs_cnt = '0;
                  end
                  st_difs_cnt = timer_inc(st_difs_cnt);
                  if (st_difs_cnt >= mac_cfg.difs_ticks) begin
                     st_clear    = 1'b1;
                     st_idle_run = 1'b0;
                  end
               end
               if (st_clear) begin
                  if (st_mode == MODE_DEFER) begin
                     st_retry   = '0;
                     st_backoff = backoff_draw(ev.random_draw);
                     st_mode    = MODE_FIRST;
                  end else if (st_mode == MODE_WAITACK &&
                               st_ack_wait >= mac_cfg.ack_timeout_ticks) begin
                     retry_or_drop(ev.random_draw, r);
                  end
               end
            end
         end
         OP_SEND: begin
            if (st_mode == MODE_IDLE) begin
               r.request_accepted = 1'b1;
               st_pending = ev.dest_addr;
               st_retry   = '0;
               start_send(TX_SEND, r);
            end
         end
         OP_FRAME: begin
            mine = (ev.frame_dest == mac_cfg.own_addr) ||
                   (ev.frame_dest == BCAST_ADDR && ev.frame_group == mac_cfg.own_group);
            if (mine) begin
               if (!ev.frame_crc_ok) begin
                  if (st_mode == MODE_WAITACK)
                     retry_or_drop(ev.random_draw, r);
                  if (ev.frame_type == FT_DATA && ev.frame_dest == BCAST_ADDR) begin
                     r.tx_command = TX_NACK;
                     r.tx_dest    = ev.frame_src;
                  end
               end else if (ev.frame_type == FT_DATA) begin
                  r.deliver_to_app = 1'b1;
                  if (ev.frame_dest != BCAST_ADDR) begin
                     r.tx_command = TX_ACK;
                     r.tx_dest    = ev.frame_src;
                  end
               end else if (ev.frame_type == FT_ACK) begin
                  if (st_mode == MODE_WAITACK || st_mode == MODE_RETRY) begin
                     r.ack_seen = 1'b1;
                     st_retry = '0;
                     st_mode  = MODE_IDLE;
                  end
               end else if (ev.frame_type == FT_NACK) begin
                  if (st_mode == MODE_IDLE)
                     start_send(TX_RESEND, r);
               end
            end
         end
         default: begin
         end
      endcase
      r.mac_status = st_mode;
      r.retry_now  = st_retry;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Event construction.
   // ------------------------------------------------------------------------
   function automatic csma_item_type tick_ev(logic busy, logic [15:0] rnd);
      csma_item_type ev;
      ev = '0;
      ev.opcode = OP_TICK;
      ev.channel_busy = busy;
      ev.random_draw = rnd;
      return ev;
   endfunction

   function automatic csma_item_type send_ev(logic [7:0] dest);
      csma_item_type ev;
      ev = '0;
      ev.opcode = OP_SEND;
      ev.dest_addr = dest;
      return ev;
   endfunction

   function automatic csma_item_type frame_ev(logic [1:0] ftype, logic crc_ok,
                                              logic [7:0] fdest, logic [7:0] fsrc,
                                              logic [7:0] fgroup);
      csma_item_type ev;
      ev = '0;
      ev.opcode = OP_FRAME;
      ev.frame_type = ftype;
      ev.frame_crc_ok = crc_ok;
      ev.frame_dest = fdest;
      ev.frame_src = fsrc;
      ev.frame_group = fgroup;
      ev.random_draw = 16'($urandom());
      return ev;
   endfunction

   // Random traffic shaped like a busy bus: mostly ticks, frames that are
   // largely addressed to this station, a steady trickle of send requests.
   // Small backoff draws dominate so that timers actually expire.
   function automatic csma_item_type rand_event();
      csma_item_type ev;
      logic [63:0] raw;
      int unsigned pick;
      int unsigned sel;
      raw = {$urandom(), $urandom()};
      ev = raw[$bits(csma_item_type)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         ev.opcode = OP_TICK;
         ev.channel_busy = ($urandom_range(0, 99) < 15);
      end else if (pick < 68) begin
         ev.opcode = OP_SEND;
         if ($urandom_range(0, 4) == 0)
            ev.dest_addr = BCAST_ADDR;
      end else if (pick < 98) begin
         ev.opcode = OP_FRAME;
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            ev.frame_dest = mac_cfg.own_addr;
         end else if (sel < 70) begin
            ev.frame_dest = BCAST_ADDR;
            if ($urandom_range(0, 4) != 0)
               ev.frame_group = mac_cfg.own_group;
         end
         sel = $urandom_range(0, 99);
         if (sel < 30)
            ev.frame_type = FT_DATA;
         else if (sel < 60)
            ev.frame_type = FT_ACK;
         else if (sel < 85)
            ev.frame_type = FT_NACK;
         else
            ev.frame_type = FT_UNKNOWN;
         ev.frame_crc_ok = ($urandom_range(0, 99) < 80);
      end else begin
         ev.opcode = OP_NONE;
      end
      if ($urandom_range(0, 3) != 0)
         ev.random_draw = 16'($urandom_range(0, 15));
      return ev;
   endfunction

   task automatic fill_random(int n);
      repeat (n) pending_events.push_back(rand_event());
   endtask

   // ------------------------------------------------------------------------
   // Register access, only ever done while nothing is in flight.
   // ------------------------------------------------------------------------
   task automatic write_reg(logic [CSR_ADDR_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic program_regs(logic [7:0] own, logic [7:0] grp, logic [15:0] difs,
                               logic [15:0] ack_to, logic [3:0] win, logic [3:0] max_att);
      write_reg(REG_OWN_ADDR, 16'(own));
      write_reg(REG_OWN_GROUP, 16'(grp));
      write_reg(REG_DIFS_TICKS, difs);
      write_reg(REG_ACK_TIMEOUT, ack_to);
      write_reg(REG_WINDOW_LOG2, 16'(win));
      write_reg(REG_MAX_ATTEMPTS, 16'(max_att));
      mac_cfg.own_addr          = own;
      mac_cfg.own_group         = grp;
      mac_cfg.difs_ticks        = difs;
      mac_cfg.ack_timeout_ticks = ack_to;
      mac_cfg.window_log2       = win;
      mac_cfg.max_attempts      = max_att;
      phases++;
   endtask

   // Every event yields one result, so an empty expectation store means the
   // pipeline is empty.
   task automatic wait_drained();
      while (pending_events.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Event driver: takes the next event from the pending queue once the
   // current beat is accepted, with a random gap between beats unless the
   // phase asks for back-to-back traffic.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      csma_item_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            ev = pending_events.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_TDATA_BITS'(ev[ITEM_DATA_BITS-1:0]);
            req_tuser  <= ev.opcode;
            req_gap = no_gaps ? 0 : $urandom_range(0, 6);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver: stalls a random number of cycles after each beat, and
   // once holds off for a long stretch so the block backs up into its input.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_wait = LONG_HOLD;
         end else if (rsp_fire) begin
            rsp_wait = no_gaps ? 0 : $urandom_range(0, 6);
         end
         if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic int field_diff(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: checks each result beat against the oldest expectation, then
   // runs the predictor for the event beat accepted on the same edge. The
   // result of an event cannot appear on the edge that accepts it, so the
   // order of the two steps does not matter.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      csma_result_type got;
      csma_result_type want;
      csma_item_type   ev_in;
      int bad;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (rsp_fire) begin
         beats_out++;
         got = rsp_tdata[RESULT_BITS-1:0];
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            bad = field_diff("tx_command", want.tx_command, got.tx_command)
                + field_diff("tx_dest", want.tx_dest, got.tx_dest)
                + field_diff("request_accepted", want.request_accepted, got.request_accepted)
                + field_diff("deliver_to_app", want.deliver_to_app, got.deliver_to_app)
                + field_diff("ack_seen", want.ack_seen, got.ack_seen)
                + field_diff("give_up", want.give_up, got.give_up)
                + field_diff("mac_status", want.mac_status, got.mac_status)
                + field_diff("retry_now", want.retry_now, got.retry_now);
            if (bad != 0)
               errors++;
         end
      end
      if (req_fire) begin
         beats_in++;
         ev_in = {req_tuser, req_tdata[ITEM_DATA_BITS-1:0]};
         want = mac_step(ev_in);
         if (want.tx_command != TX_NONE)
            tx_count++;
         if (want.give_up)
            give_up_count++;
         if (want.deliver_to_app)
            deliver_count++;
         expected_results.push_back(want);
      end
      // Watchdog: a long run of cycles with no beat on either side means
      // the block has hung.
      if (!reset) begin
         if (req_fire || rsp_fire)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      mac_reset();
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Short timers make each corner reachable in a few
      // events: an ACK timeout into retry backoff, a backoff frozen by a busy
      // tick, a bad-CRC frame that exhausts the retries, NACK handling for
      // multicast data, resend on a NACK while idle, a request ignored while
      // deferred, and the frames that the address filter drops.
      program_regs(8'hFE, 8'hFF, 16'd2, 16'd2, 4'd1, 4'd1);
      pending_events.push_back(send_ev(8'h00));
      pending_events.push_back(tick_ev(1'b0, 16'h0000));
      pending_events.push_back(tick_ev(1'b0, 16'hFFFF));
      pending_events.push_back(tick_ev(1'b1, 16'h0000));
      pending_events.push_back(tick_ev(1'b0, 16'h5A5A));
      pending_events.push_back(tick_ev(1'b0, 16'hA5A5));
      pending_events.push_back(frame_ev(FT_NACK, 1'b0, 8'hFE, 8'h11, 8'h00));
      pending_events.push_back(frame_ev(FT_DATA, 1'b0, BCAST_ADDR, 8'hFF, 8'hFF));
      pending_events.push_back(frame_ev(FT_DATA, 1'b1, 8'hFE, 8'h00, 8'h00));
      pending_events.push_back(frame_ev(FT_DATA, 1'b1, BCAST_ADDR, 8'h42, 8'hFF));
      pending_events.push_back(frame_ev(FT_NACK, 1'b1, 8'hFE, 8'h42, 8'h00));
      pending_events.push_back(frame_ev(FT_ACK, 1'b1, 8'hFE, 8'h00, 8'h00));
      pending_events.push_back(frame_ev(FT_DATA, 1'b1, 8'h07, 8'h01, 8'hFF));
      pending_events.push_back(frame_ev(FT_DATA, 1'b1, BCAST_ADDR, 8'h01, 8'h00));
      pending_events.push_back(frame_ev(FT_UNKNOWN, 1'b1, 8'hFE, 8'h01, 8'hFF));
      pending_events.push_back(send_ev(BCAST_ADDR));
      pending_events.push_back(tick_ev(1'b1, 16'hFFFF));
      pending_events.push_back(send_ev(8'h09));
      pending_events.push_back(send_ev(8'h03));
      pending_events.push_back(tick_ev(1'b0, 16'h0000));
      pending_events.push_back(tick_ev(1'b0, 16'h0000));
      pending_events.push_back(tick_ev(1'b0, 16'h0000));
      pending_events.push_back(frame_ev(FT_ACK, 1'b1, 8'hFE, 8'h09, 8'h00));
      pending_events.push_back(rand_event());
      pending_events[pending_events.size()-1].opcode = OP_NONE;
      pending_events.push_back(frame_ev(FT_ACK, 1'b1, 8'hFE, 8'h09, 8'h00));
      wait_drained();

      // Short timers with back-to-back beats on both sides.
      no_gaps = 1'b1;
      program_regs(8'd5, 8'd3, 16'd3, 16'd4, 4'd2, 4'd3);
      fill_random(320);
      wait_drained();

      // Random idling, with one long receiver hold-off partway through.
      no_gaps = 1'b0;
      program_regs(8'($urandom_range(0, 254)), 8'($urandom()), 16'($urandom_range(1, 6)),
                   16'($urandom_range(1, 24)), 4'($urandom_range(0, 5)),
                   4'($urandom_range(0, 4)));
      fill_random(320);
      while (pending_events.size() > 200) @(posedge clock);
      long_hold_req = 1'b1;
      wait_drained();

      // Largest timers, a window exponent of 10 and the most retries allowed.
      program_regs(8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 4'd10, 4'd15);
      fill_random(150);
      wait_drained();

      // Clear on the first idle tick, instant ACK timeout, many retries.
      program_regs(8'hFE, 8'hFF, 16'd0, 16'd1, 4'd0, 4'd15);
      fill_random(320);
      wait_drained();

      // Wide window with many retries so the window exponent passes the
      // timer width.
      program_regs(8'($urandom_range(0, 254)), 8'($urandom()), 16'd1, 16'd1, 4'd10, 4'd15);
      fill_random(320);
      wait_drained();

      // Two more random settings, where the retry limit may be zero.
      repeat (2) begin
         program_regs(8'($urandom_range(0, 254)), 8'($urandom()),
                      16'($urandom_range(1, 6)), 16'($urandom_range(1, 24)),
                      4'($urandom_range(0, 5)), 4'($urandom_range(0, 4)));
         fill_random(250);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived, expected more, actual none",
                  $time, expected_results.size());
         errors++;
      end
      $display("Covered %0d event beats and %0d result beats over %0d register settings.",
               beats_in, beats_out, phases);
      $display("Saw %0d transmit commands, %0d deliveries, %0d give-ups; %0d failing beats.",
               tx_count, deliver_count, give_up_count, errors);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
